// ===== design/pfrgba_pkg.sv =====
// Shared types, constants and helpers of the pixel format converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfrgba_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef logic [1:0] pos_t [4];

	// Byte places of R, G, B, A for the four channel orders RGBX, BGRX, XRGB, XBGR
	localparam pos_t RGB_POS [4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd2, 2'd1, 2'd0, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd0},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

	localparam logic [4:0] FMT_IDX8      = 5'd6;
	localparam logic [4:0] FMT_GRAY8     = 5'd7;
	localparam logic [4:0] FMT_GRAY16    = 5'd8;
	localparam logic [4:0] FMT_GA8       = 5'd9;
	localparam logic [4:0] FMT_GA16      = 5'd10;
	localparam logic [4:0] FMT_RGB24     = 5'd11;
	localparam logic [4:0] FMT_BGR24     = 5'd12;
	localparam logic [4:0] FMT_RGB48     = 5'd13;
	localparam logic [4:0] FMT_BGR48     = 5'd14;
	localparam logic [4:0] FMT_X32_FIRST = 5'd15;
	localparam logic [4:0] FMT_A32_FIRST = 5'd19;
	localparam logic [4:0] FMT_X64_FIRST = 5'd23;
	localparam logic [4:0] FMT_A64_FIRST = 5'd27;
	localparam logic [4:0] FMT_YCC       = 5'd31;

	localparam logic [1:0] CFG_FORMAT  = 2'd0;
	localparam logic [1:0] CFG_ORDER   = 2'd1;
	localparam logic [1:0] CFG_WIDTH   = 2'd2;
	localparam logic [1:0] CFG_PALSIZE = 2'd3;

	// floor(v/257): with v = 256h + l the quotient is h, or h-1 when l < h
	function automatic logic [7:0] div257(input logic [15:0] v);
		return (v[7:0] < v[15:8]) ? (v[15:8] - 8'd1) : v[15:8];
	endfunction

endpackage
`default_nettype wire

// ===== design/pfrgba_convert.sv =====
// Combinational channel extraction for all input formats.
// Depends on pfrgba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfrgba_convert import pfrgba_pkg::*; (
	input  wire logic [4:0]  fmt,
	input  wire logic [63:0] raw,
	input  wire logic [2:0]  sub,
	output rgba_t            chan,
	output logic             use_pal,
	output logic [7:0]       pal_idx
);

	function automatic logic [7:0] ycc_chan(input logic [7:0] y,
			input logic signed [31:0] sum);
		logic signed [31:0] t;
		t = $signed({8'd0, y, 16'd0}) + sum;
		if (t < 0) return 8'd0;
		if (t[31:16] > 16'sd255) return 8'd255;
		return t[23:16];
	endfunction

	logic [7:0]  bt [8];
	logic [7:0]  hf [4];
	logic [7:0]  shifted;
	logic [7:0]  field;
	logic signed [31:0] cb, cr;

	always_comb begin
		for (int i = 0; i < 8; i++) bt[i] = raw[8*i +: 8];
		for (int i = 0; i < 4; i++) hf[i] = div257(raw[16*i +: 16]);
	end

	// Packed sub-byte pixels, most significant bits first
	assign shifted = bt[0] << (sub << fmt[2:1]);
	always_comb begin
		case (fmt[2:1])
			2'd0:    field = {8{shifted[7]}};
			2'd1:    field = {4{shifted[7:6]}};
			default: field = {2{shifted[7:4]}};
		endcase
	end

	assign cb = 32'(signed'({1'b0, bt[1]}) - 10'sd128);
	assign cr = 32'(signed'({1'b0, bt[2]}) - 10'sd128);

	always_comb begin
		pos_t p;
		p = RGB_POS[0];
		chan = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
		use_pal = 1'b0;
		pal_idx = 8'd0;
		if (fmt < FMT_IDX8) begin
			use_pal = ~fmt[0];
			case (fmt[2:1])
				2'd0:    pal_idx = {7'd0, shifted[7]};
				2'd1:    pal_idx = {6'd0, shifted[7:6]};
				default: pal_idx = {4'd0, shifted[7:4]};
			endcase
			chan.r = field; chan.g = field; chan.b = field;
		end else if (fmt == FMT_IDX8) begin
			use_pal = 1'b1;
			pal_idx = bt[0];
		end else if (fmt == FMT_GRAY8) begin
			chan.r = bt[0]; chan.g = bt[0]; chan.b = bt[0];
		end else if (fmt == FMT_GRAY16) begin
			chan.r = hf[0]; chan.g = hf[0]; chan.b = hf[0];
		end else if (fmt == FMT_GA8) begin
			chan = '{r: bt[0], g: bt[0], b: bt[0], a: bt[1]};
		end else if (fmt == FMT_GA16) begin
			chan = '{r: hf[0], g: hf[0], b: hf[0], a: hf[1]};
		end else if (fmt == FMT_RGB24 || fmt == FMT_BGR24) begin
			p = RGB_POS[{1'b0, ~fmt[0]}];
			chan = '{r: bt[3'(p[0])], g: bt[3'(p[1])], b: bt[3'(p[2])], a: 8'd255};
		end else if (fmt == FMT_RGB48 || fmt == FMT_BGR48) begin
			p = RGB_POS[{1'b0, ~fmt[0]}];
			chan = '{r: hf[p[0]], g: hf[p[1]], b: hf[p[2]], a: 8'd255};
		end else if (fmt < FMT_X64_FIRST) begin
			p = RGB_POS[2'(fmt - FMT_X32_FIRST)];
			chan = '{r: bt[3'(p[0])], g: bt[3'(p[1])], b: bt[3'(p[2])],
				a: (fmt >= FMT_A32_FIRST) ? bt[3'(p[3])] : 8'd255};
		end else if (fmt < FMT_YCC) begin
			p = RGB_POS[2'(fmt - FMT_X64_FIRST)];
			chan = '{r: hf[p[0]], g: hf[p[1]], b: hf[p[2]],
				a: (fmt >= FMT_A64_FIRST) ? hf[p[3]] : 8'd255};
		end else begin
			chan.r = ycc_chan(bt[0], 32'sd91881 * cr);
			chan.g = ycc_chan(bt[0], -(32'sd22554 * cb) - 32'sd46802 * cr);
			chan.b = ycc_chan(bt[0], 32'sd116130 * cb);
		end
	end

endmodule
`default_nettype wire

// ===== design/pixel_format_to_rgba32.sv =====
// Top level of the pixel format converter: input register, pixel issue,
// palette memory, output register. Depends on pfrgba_pkg and pfrgba_convert.
`timescale 1ns / 1ps
`default_nettype none
// Converts raw pixel words to 32-bit RGBA-family pixels at one pixel per clock
// when the output is not stalled. Each convert transaction gives one pixel,
// except packed 1, 2 and 4-bit formats, which give up to 8, 4 or 2 pixels (cut
// at the row end) and hold the input channel until the last of them issues,
// since the single output port moves one pixel a cycle. Palette-write
// transactions give no pixel. Three registers lie on the path: input register,
// a stage that holds the palette read, and the output register. Configure only
// while the block is idle.
module pixel_format_to_rgba32 import pfrgba_pkg::*; #(
	parameter int PALETTE_DEPTH = 256,
	parameter int WIDTH_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [63:0] raw_word,
	input  wire logic [7:0]  entry_index,
	input  wire logic [31:0] entry_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_out,
	output logic             last_of_item,
	output logic             error_code
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = ((WIDTH_BITS > 16) ? WIDTH_BITS : 16) + 1;

	function automatic logic [31:0] pack_px(input rgba_t c, input logic [2:0] o);
		logic [31:0] v;
		pos_t p;
		p = RGB_POS[o[1:0]];
		v = '0;
		v[{p[0], 3'b000} +: 8] = c.r;
		v[{p[1], 3'b000} +: 8] = c.g;
		v[{p[2], 3'b000} +: 8] = c.b;
		if (o[2]) v[{p[3], 3'b000} +: 8] = c.a;
		return v;
	endfunction

	// Configuration
	logic [4:0]  format_q;
	logic [2:0]  order_q;
	logic [15:0] width_q;
	logic [8:0]  palsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q  <= 5'd0;
			order_q   <= 3'd4;
			width_q   <= 16'd1;
			palsize_q <= 9'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FORMAT:  format_q  <= cfg_data[4:0];
				CFG_ORDER:   order_q   <= cfg_data[2:0];
				CFG_WIDTH:   width_q   <= cfg_data;
				CFG_PALSIZE: palsize_q <= cfg_data[8:0];
				default:     ;
			endcase
		end
	end

	// Whole pipeline moves when the output register is free or being taken
	logic adv;
	assign adv = !out_valid || !out_stall;

	// Stage 1: input register and pixel issue
	logic                   v_s1, action_s1;
	logic [63:0]            raw_s1;
	logic [7:0]             eidx_s1;
	logic [31:0]            ecolor_s1;
	logic [2:0]             k_s1;
	logic [WIDTH_BITS-1:0]  col_q;

	logic [CW-1:0] w_eff, col0, rem, col_next;
	logic [3:0]    per, n_s1;
	logic          last_s1, done_s1, accept;

	assign w_eff = (width_q == 16'd0) ? CW'(1) : CW'(width_q);
	// A column left past a lowered width starts a new row
	assign col0  = (CW'(col_q) >= w_eff) ? '0 : CW'(col_q);
	assign rem   = w_eff - col0;
	assign per   = (format_q < FMT_IDX8) ? (4'd8 >> format_q[2:1]) : 4'd1;
	assign n_s1  = (rem < CW'(per)) ? rem[3:0] : per;
	assign last_s1  = !action_s1 || ({1'b0, k_s1} == n_s1 - 4'd1);
	assign done_s1  = !v_s1 || last_s1;
	assign in_stall = !(adv && done_s1);
	assign accept   = in_valid && !in_stall;
	assign col_next = (col0 + CW'(n_s1) >= w_eff) ? '0 : col0 + CW'(n_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			k_s1  <= 3'd0;
			col_q <= '0;
		end else if (adv) begin
			if (done_s1) begin
				v_s1 <= accept;
				k_s1 <= 3'd0;
			end else begin
				k_s1 <= k_s1 + 3'd1;
			end
			// Advance the column once the last pixel of the transaction issues
			if (v_s1 && action_s1 && last_s1) col_q <= col_next[WIDTH_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			raw_s1    <= raw_word;
			eidx_s1   <= entry_index;
			ecolor_s1 <= entry_color;
		end
	end

	rgba_t      chan;
	logic       use_pal;
	logic [7:0] pal_idx;
	logic [8:0] lim;
	logic       pal_err;

	pfrgba_convert u_convert (
		.fmt     (format_q),
		.raw     (raw_s1),
		.sub     (k_s1),
		.chan    (chan),
		.use_pal (use_pal),
		.pal_idx (pal_idx)
	);

	assign lim     = (palsize_q < 9'(PALETTE_DEPTH)) ? palsize_q : 9'(PALETTE_DEPTH);
	assign pal_err = use_pal && ({1'b0, pal_idx} >= lim);

	// Palette memory: write from palette transactions, registered read
	logic [31:0] pal_mem [PALETTE_DEPTH];
	logic [31:0] rd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s1 && !action_s1 && ({1'b0, eidx_s1} < 9'(PALETTE_DEPTH)))
				pal_mem[eidx_s1[AW-1:0]] <= ecolor_s1;
			rd_s2 <= pal_mem[pal_idx[AW-1:0]];
		end
	end

	// Stage 2
	logic  v_s2, pal_s2, err_s2, last_s2;
	rgba_t chan_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1 && action_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_s2 <= chan;
			pal_s2  <= use_pal;
			err_s2  <= pal_err;
			last_s2 <= last_s1;
		end
	end

	// Output register; an out-of-range palette index gives a zero pixel
	rgba_t pal_c;
	assign pal_c = '{r: rd_s2[7:0], g: rd_s2[15:8], b: rd_s2[23:16], a: rd_s2[31:24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_out    <= err_s2 ? 32'd0 : pack_px(pal_s2 ? pal_c : chan_s2, order_q);
			last_of_item <= last_s2;
			error_code   <= err_s2;
		end
	end

	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> adv) else $error("input taken while output blocked");
	a_pal_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 && !action_s1 |=> !v_s2) else $error("palette write made a pixel");
	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && action_s1 |-> ({1'b0, k_s1} < n_s1)) else $error("sub-pixel past count");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code |-> pixel_out == 32'd0) else $error("error pixel not zero");

endmodule
`default_nettype wire
